[src/krd_pkg.sv]
// shared types, codes and defaults for the keyed record deque
package krd_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 64;

   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_FIND       = 3'd4;
   localparam logic [2:0] MODE_SET_SCORE  = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]         mode;
      logic [63:0]        record_key;
      logic [7:0]         record_age;
      logic signed [31:0] record_score;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         length;
      logic [63:0]        out_key;
      logic [7:0]         out_age;
      logic signed [31:0] out_score;
   } rsp_type;

   typedef struct packed {
      logic [63:0]        key;
      logic [7:0]         age;
      logic signed [31:0] score;
   } rec_type;

   typedef struct packed {
      logic rec_en;
      logic score_en;
   } store_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_READ,
      ST_SCAN,
      ST_RESP
   } krd_state_type;

endpackage

[src/krd_store.sv]
// record memory: one write port, one registered read port
module krd_store #(
   parameter int DEPTH    = krd_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = krd_pkg::KEY_BITS_DEFAULT
) (
   input  logic                       clock,
   input  krd_pkg::store_wr_type      wr,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  krd_pkg::rec_type           wr_rec,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output krd_pkg::rec_type           rd_rec
);
   import krd_pkg::*;

   logic [KEY_BITS-1:0] key_mem   [DEPTH];
   logic [7:0]          age_mem   [DEPTH];
   logic signed [31:0]  score_mem [DEPTH];

   rec_type rd_rec_ff;

   always_ff @(posedge clock) begin
      if (wr.rec_en) begin
         key_mem[wr_addr] <= wr_rec.key[KEY_BITS-1:0];
         age_mem[wr_addr] <= wr_rec.age;
      end
      if (wr.rec_en || wr.score_en) begin
         score_mem[wr_addr] <= wr_rec.score;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_rec_ff.key   <= 64'(key_mem[rd_addr]);
         rd_rec_ff.age   <= age_mem[rd_addr];
         rd_rec_ff.score <= score_mem[rd_addr];
      end
   end

   assign rd_rec = rd_rec_ff;

endmodule

[src/keyed_record_deque.sv]
// keyed record deque top level: control sequencer, pointers and result register
//
// Holds up to DEPTH records (key, age, score) in a circular record memory addressed
// from a front pointer. One item is worked at a time; req_ready is high only while the
// block is idle, and the result register lets a new item be taken while the last result
// still waits for rsp_ready. A push, a pop or search on an empty deque, and unused modes
// go from the execute step straight to the response step; a pop passes through a pop
// read step; a find or set score reads the records one by one from the front until the
// key matches or the last held record has been read. The search time comes from the
// single read port of the record memory, which returns one entry per cycle.
module keyed_record_deque #(
   parameter int DEPTH    = krd_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = krd_pkg::KEY_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  krd_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output krd_pkg::rsp_type  rsp_payload
);
   import krd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [AW:0]   DEPTH_WIDE = (AW + 1)'(DEPTH);
   localparam logic [63:0]   KEY_MASK   = {64{1'b1}} >> (64 - KEY_BITS);

   krd_state_type state_ff, state_in;
   req_type       item_ff;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [1:0]    status_ff, status_in;
   rec_type       rec_ff, rec_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   store_wr_type  wr;
   logic [AW-1:0] wr_addr;
   rec_type       wr_rec;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   rec_type       rd_rec;

   logic          req_xfer;
   logic          rsp_free;
   logic [63:0]   item_key;
   logic [CW-1:0] fill_m1;
   logic [CW-1:0] pos_wide;
   logic          key_hit;
   logic          scan_last;
   logic [AW-1:0] slot_next;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_WIDE) begin
         s = s - DEPTH_WIDE;
      end
      return s[AW-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign item_key  = item_ff.record_key & KEY_MASK;
   assign fill_m1   = fill_ff - CW'(1);
   assign pos_wide  = CW'(pos_ff) + CW'(1);
   assign key_hit   = (rd_rec.key == item_key);
   assign scan_last = (pos_wide == fill_ff);
   assign slot_next = (slot_ff == LAST_SLOT) ? '0 : slot_ff + AW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            unique case (item_ff.mode) inside
               MODE_POP_FRONT, MODE_POP_BACK: begin
                  if (fill_ff != '0) begin
                     state_in = ST_POP_READ;
                  end
               end
               MODE_FIND, MODE_SET_SCORE: begin
                  if (fill_ff != '0) begin
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_POP_READ: begin
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (key_hit || scan_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      front_in     = front_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      rec_in       = rec_ff;
      wr           = '0;
      wr_addr      = '0;
      wr_rec       = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            rec_in    = '0;
            unique case (item_ff.mode) inside
               MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                  if (fill_ff == FULL_COUNT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr.rec_en    = 1'b1;
                     wr_rec.key   = item_key;
                     wr_rec.age   = item_ff.record_age;
                     wr_rec.score = item_ff.record_score;
                     fill_in      = fill_ff + CW'(1);
                     if (item_ff.mode == MODE_PUSH_FRONT) begin
                        front_in = (front_ff == '0) ? LAST_SLOT : front_ff - AW'(1);
                        wr_addr  = front_in;
                     end else begin
                        wr_addr = wrap_add(front_ff, fill_ff[AW-1:0]);
                     end
                  end
               end
               MODE_POP_FRONT, MODE_POP_BACK: begin
                  if (fill_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     rd_en   = 1'b1;
                     fill_in = fill_m1;
                     if (item_ff.mode == MODE_POP_FRONT) begin
                        rd_addr  = front_ff;
                        front_in = wrap_add(front_ff, AW'(1));
                     end else begin
                        rd_addr = wrap_add(front_ff, fill_m1[AW-1:0]);
                     end
                  end
               end
               MODE_FIND, MODE_SET_SCORE: begin
                  if (fill_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = front_ff;
                     pos_in  = '0;
                     slot_in = front_ff;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         ST_POP_READ: begin
            rec_in = rd_rec;
         end
         ST_SCAN: begin
            if (key_hit) begin
               status_in = STATUS_OK;
               rec_in    = rd_rec;
               if (item_ff.mode == MODE_SET_SCORE) begin
                  wr.score_en  = 1'b1;
                  wr_addr      = slot_ff;
                  wr_rec.score = item_ff.record_score;
                  rec_in.score = item_ff.record_score;
               end
            end else if (scan_last) begin
               status_in = STATUS_NOT_FOUND;
               rec_in    = '0;
            end else begin
               rd_en   = 1'b1;
               rd_addr = slot_next;
               slot_in = slot_next;
               pos_in  = pos_ff + AW'(1);
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = status_ff;
               rsp_in.length     = 5'(fill_ff);
               rsp_in.out_key    = rec_ff.key;
               rsp_in.out_age    = rec_ff.age;
               rsp_in.out_score  = rec_ff.score;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_payload;
      end
      pos_ff    <= pos_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      rec_ff    <= rec_in;
      rsp_ff    <= rsp_in;
   end

   krd_store #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (wr_addr),
      .wr_rec  (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_rec  (rd_rec)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("fill count above depth");

   a_fill_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(fill_ff)) |-> $past(state_ff == ST_EXEC))
      else $error("fill count changed outside execute step");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CW'(pos_ff) < fill_ff))
      else $error("search position beyond held records");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside response step");

endmodule
